// ===== src/gha_pkg.sv =====
`timescale 1ns / 1ps

package gha_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STALE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== src/gha_ram.sv =====
`timescale 1ns / 1ps

module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gha_ctrl.sv =====
`timescale 1ns / 1ps

module gha_ctrl
  import gha_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int GEN_WIDTH = 16,
  parameter int IDX_W     = $clog2(SLOTS),
  parameter int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [IDX_W-1:0]     slot_index,
  input  logic [GEN_WIDTH-1:0] slot_generation,
  output logic                 done,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     handle_index,
  output logic [GEN_WIDTH-1:0] handle_generation,
  output logic [IDX_W-1:0]     slot_raddr,
  input  logic [GEN_WIDTH:0]   slot_rdata,
  output logic                 slot_we,
  output logic [IDX_W-1:0]     slot_waddr,
  output logic [GEN_WIDTH:0]   slot_wdata,
  output logic [IDX_W-1:0]     stk_raddr,
  input  logic [IDX_W-1:0]     stk_rdata,
  output logic                 stk_we,
  output logic [IDX_W-1:0]     stk_waddr,
  output logic [IDX_W-1:0]     stk_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_ALLOC_RD,
    S_SLOT_RD
  } state_t;

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  state_t               state;
  logic [CNT_W-1:0]     free_count;
  logic [CNT_W-1:0]     used_count;
  logic [1:0]           cmd;
  logic [IDX_W-1:0]     idx;
  logic [GEN_WIDTH-1:0] gen;

  logic                 take;
  logic                 fresh_alloc;
  logic                 idx_known;
  logic                 handle_ok;
  logic [CNT_W-1:0]     free_top;

  assign busy        = (state != S_IDLE);
  assign take        = start && !busy;
  assign free_top    = free_count - CNT_W'(1);
  assign fresh_alloc = take && (command == CMD_ALLOC) && (free_count == '0) &&
                       (used_count < SLOTS_C);
  assign idx_known   = CNT_W'(slot_index) < used_count;
  assign handle_ok   = slot_rdata[GEN_WIDTH] && (slot_rdata[GEN_WIDTH-1:0] == gen);

  assign stk_raddr   = free_top[IDX_W-1:0];

  always_comb begin
    slot_raddr = slot_index;
    if (state == S_POP) begin
      slot_raddr = stk_rdata;
    end
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = idx;
    slot_wdata = {1'b1, slot_rdata[GEN_WIDTH-1:0]};
    stk_we     = 1'b0;
    stk_waddr  = free_count[IDX_W-1:0];
    stk_wdata  = idx;
    unique case (state)
      S_IDLE: begin
        if (fresh_alloc) begin
          slot_we    = 1'b1;
          slot_waddr = used_count[IDX_W-1:0];
          slot_wdata = {1'b1, {GEN_WIDTH{1'b0}}};
        end
      end
      S_ALLOC_RD: begin
        slot_we = 1'b1;
      end
      S_SLOT_RD: begin
        if (handle_ok && (cmd == CMD_RELEASE)) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b0, slot_rdata[GEN_WIDTH-1:0] + GEN_WIDTH'(1)};
          stk_we     = (free_count < SLOTS_C);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            cmd               <= command;
            idx               <= slot_index;
            gen               <= slot_generation;
            status            <= ST_STALE;
            handle_index      <= slot_index;
            handle_generation <= slot_generation;
            if (command == CMD_ALLOC) begin
              if (free_count != '0) begin
                free_count <= free_top;
                state      <= S_POP;
              end else if (used_count < SLOTS_C) begin
                used_count        <= used_count + CNT_W'(1);
                status            <= ST_OK;
                handle_index      <= used_count[IDX_W-1:0];
                handle_generation <= '0;
                done              <= 1'b1;
              end else begin
                status <= ST_FULL;
                done   <= 1'b1;
              end
            end else if (((command == CMD_RELEASE) || (command == CMD_CHECK)) &&
                         idx_known) begin
              state <= S_SLOT_RD;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_POP: begin
          idx   <= stk_rdata;
          state <= S_ALLOC_RD;
        end
        S_ALLOC_RD: begin
          status            <= ST_OK;
          handle_index      <= idx;
          handle_generation <= slot_rdata[GEN_WIDTH-1:0];
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_SLOT_RD: begin
          if (handle_ok) begin
            status <= ST_OK;
            if ((cmd == CMD_RELEASE) && (free_count < SLOTS_C)) begin
              free_count <= free_count + CNT_W'(1);
            end
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/generational_handle_allocator.sv =====
`timescale 1ns / 1ps

// Generational handle allocator. A command transfer is taken when start is
// high and busy is low; its result appears on status, handle_index and
// handle_generation for exactly one cycle with done high, and the receiver
// cannot hold it off. The result of an allocate of a never-used slot, of a
// full table, of an unknown command and of a handle whose index was never
// handed out arrives in the cycle after the transfer. Release and check of
// a known index first wait for the registered read of the slot memory, and
// an allocate that reuses a freed slot makes one read of the free stack
// memory followed by one of the slot memory. Busy is high in between, and a
// new command may be given in the cycle that done is high.
// No clearing pass is needed after reset.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int GEN_WIDTH = 16,
  parameter int IDX_W     = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [IDX_W-1:0]     slot_index,
  input  logic [GEN_WIDTH-1:0] slot_generation,
  output logic                 done,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     handle_index,
  output logic [GEN_WIDTH-1:0] handle_generation
);

  logic [IDX_W-1:0]   slot_raddr;
  logic [GEN_WIDTH:0] slot_rdata;
  logic               slot_we;
  logic [IDX_W-1:0]   slot_waddr;
  logic [GEN_WIDTH:0] slot_wdata;
  logic [IDX_W-1:0]   stk_raddr;
  logic [IDX_W-1:0]   stk_rdata;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_waddr;
  logic [IDX_W-1:0]   stk_wdata;

  gha_ctrl #(
    .SLOTS     (SLOTS),
    .GEN_WIDTH (GEN_WIDTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .command           (command),
    .slot_index        (slot_index),
    .slot_generation   (slot_generation),
    .done              (done),
    .status            (status),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .slot_raddr        (slot_raddr),
    .slot_rdata        (slot_rdata),
    .slot_we           (slot_we),
    .slot_waddr        (slot_waddr),
    .slot_wdata        (slot_wdata),
    .stk_raddr         (stk_raddr),
    .stk_rdata         (stk_rdata),
    .stk_we            (stk_we),
    .stk_waddr         (stk_waddr),
    .stk_wdata         (stk_wdata)
  );

  gha_ram #(
    .WIDTH (GEN_WIDTH + 1),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

`ifndef SYNTHESIS
  a_transfer_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("Accepted command neither busy nor done");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("Result strobe without a pending command");

  a_full_echo: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (handle_index == $past(slot_index)))
    else $error("Table full result does not echo the index");
`endif

endmodule

// ===== tb/sv/generational_handle_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int SLOTS = 64;
  localparam int GEN_W = 16;
  localparam int IDX_W = 6;
  localparam int PHASE_ITEMS = 255;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] generation;
  } outcome_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    int               reps;
    bit               typed;
    outcome_t         want;
  } step_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       command = CMD_ALLOC;
  logic [IDX_W-1:0] slot_index = '0;
  logic [GEN_W-1:0] slot_generation = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [IDX_W-1:0] handle_index;
  logic [GEN_W-1:0] handle_generation;

  logic [GEN_W-1:0] table_gen [SLOTS];
  bit               table_alive [SLOTS];
  int               table_used = 0;
  logic [IDX_W-1:0] free_slots [$];
  int               live_slots [$];

  outcome_t pending_outcomes [$];
  outcome_t oldest;
  int       errors = 0;
  int       quiet_cycles = 0;
  int       sender_idle_pct = 7;

  step_t directed [24] = '{
    '{CMD_CHECK,   6'd0,  16'h0000, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0000}},
    '{CMD_RELEASE, 6'd63, 16'hFFFF, 1,  1'b1, '{ST_STALE, 6'd63, 16'hFFFF}},
    '{CMD_UNKNOWN, 6'd63, 16'hFFFF, 1,  1'b1, '{ST_STALE, 6'd63, 16'hFFFF}},
    '{CMD_ALLOC,   6'd21, 16'h1234, 1,  1'b1, '{ST_OK,    6'd0,  16'h0000}},
    '{CMD_CHECK,   6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd0,  16'h0000}},
    '{CMD_CHECK,   6'd0,  16'h0001, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0001}},
    '{CMD_CHECK,   6'd0,  16'h8000, 1,  1'b1, '{ST_STALE, 6'd0,  16'h8000}},
    '{CMD_RELEASE, 6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd0,  16'h0000}},
    '{CMD_RELEASE, 6'd0,  16'h0000, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0000}},
    '{CMD_CHECK,   6'd0,  16'h0000, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0000}},
    '{CMD_ALLOC,   6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd0,  16'h0001}},
    '{CMD_CHECK,   6'd0,  16'h0001, 1,  1'b1, '{ST_OK,    6'd0,  16'h0001}},
    '{CMD_ALLOC,   6'd0,  16'h0000, 63, 1'b0, '{ST_OK,    6'd0,  16'h0000}},
    '{CMD_ALLOC,   6'd42, 16'hBEEF, 1,  1'b1, '{ST_FULL,  6'd42, 16'hBEEF}},
    '{CMD_CHECK,   6'd63, 16'h0000, 1,  1'b1, '{ST_OK,    6'd63, 16'h0000}},
    '{CMD_RELEASE, 6'd63, 16'h0000, 1,  1'b1, '{ST_OK,    6'd63, 16'h0000}},
    '{CMD_RELEASE, 6'd5,  16'h0000, 1,  1'b1, '{ST_OK,    6'd5,  16'h0000}},
    '{CMD_ALLOC,   6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd5,  16'h0001}},
    '{CMD_ALLOC,   6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd63, 16'h0001}},
    '{CMD_ALLOC,   6'd63, 16'hFFFF, 1,  1'b1, '{ST_FULL,  6'd63, 16'hFFFF}},
    '{CMD_UNKNOWN, 6'd0,  16'h0001, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0001}},
    '{CMD_RELEASE, 6'd0,  16'h0001, 1,  1'b1, '{ST_OK,    6'd0,  16'h0001}},
    '{CMD_CHECK,   6'd0,  16'h0002, 1,  1'b1, '{ST_STALE, 6'd0,  16'h0002}},
    '{CMD_ALLOC,   6'd0,  16'h0000, 1,  1'b1, '{ST_OK,    6'd0,  16'h0002}}
  };

  generational_handle_allocator #(
    .SLOTS(SLOTS),
    .GEN_WIDTH(GEN_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .slot_index(slot_index),
    .slot_generation(slot_generation),
    .done(done),
    .status(status),
    .handle_index(handle_index),
    .handle_generation(handle_generation)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic outcome_t apply_to_table(input logic [1:0] cmd,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [GEN_W-1:0] gen);
    outcome_t r;
    int k;
    bit valid;
    r = '{ST_STALE, idx, gen};
    valid = (idx < table_used) && table_alive[idx] && (table_gen[idx] == gen);
    case (cmd)
      CMD_ALLOC: begin
        if (free_slots.size() != 0) begin
          k = free_slots[free_slots.size() - 1];
          free_slots.delete(free_slots.size() - 1);
        end else if (table_used < SLOTS) begin
          k = table_used;
          table_used++;
          table_gen[k] = '0;
        end else begin
          k = -1;
        end
        if (k < 0) begin
          r.status = ST_FULL;
        end else begin
          table_alive[k] = 1'b1;
          live_slots.insert(live_slots.size(), k);
          r = '{ST_OK, IDX_W'(k), table_gen[k]};
        end
      end
      CMD_RELEASE: begin
        if (valid) begin
          table_alive[idx] = 1'b0;
          table_gen[idx] = table_gen[idx] + 1'b1;
          free_slots.insert(free_slots.size(), idx);
          for (int i = 0; i < live_slots.size(); i++) begin
            if (live_slots[i] == idx) begin
              live_slots.delete(i);
              break;
            end
          end
          r.status = ST_OK;
        end
      end
      CMD_CHECK: begin
        if (valid) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                       input logic [GEN_W-1:0] gen, input bit typed,
                       input outcome_t want);
    outcome_t predicted;
    start <= 1'b1;
    command <= cmd;
    slot_index <= idx;
    slot_generation <= gen;
    do @(posedge clk); while (busy);
    predicted = apply_to_table(cmd, idx, gen);
    pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  task automatic pick_command(input int alloc_pct, output logic [1:0] cmd,
                              output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
    int roll;
    int pick;
    cmd = CMD_ALLOC;
    idx = IDX_W'($urandom);
    gen = GEN_W'($urandom);
    roll = $urandom_range(99);
    if (roll < alloc_pct) return;
    roll = $urandom_range(99);
    if (live_slots.size() != 0 && roll < 70) begin
      pick = live_slots[$urandom_range(live_slots.size() - 1)];
      idx = IDX_W'(pick);
      gen = table_gen[pick];
      cmd = (roll < 45) ? CMD_RELEASE : (roll < 65) ? CMD_CHECK : CMD_UNKNOWN;
    end else if (table_used != 0 && roll < 85) begin
      // Current, previous or older generation of a slot that has been handed out.
      idx = IDX_W'($urandom_range(table_used - 1));
      gen = table_gen[idx] - GEN_W'($urandom_range(2));
      cmd = $urandom_range(1) ? CMD_RELEASE : CMD_CHECK;
    end else begin
      cmd = 2'($urandom_range(1, 3));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d index %0d generation %0d",
               status, handle_index, handle_generation);
        errors++;
      end else begin
        oldest = pending_outcomes.pop_front();
        if (status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status);
          errors++;
        end
        if (handle_index !== oldest.index) begin
          $error("handle_index: expected %0d, got %0d", oldest.index, handle_index);
          errors++;
        end
        if (handle_generation !== oldest.generation) begin
          $error("handle_generation: expected %0d, got %0d",
                 oldest.generation, handle_generation);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    int               window_left;
    bit               alloc_heavy;
    window_left = 0;
    alloc_heavy = 1'b0;
    foreach (table_gen[i]) begin
      table_gen[i] = '0;
      table_alive[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      for (int n = 0; n < directed[i].reps; n++) begin
        sender_gap();
        issue(directed[i].cmd, directed[i].idx, directed[i].gen, directed[i].typed,
              directed[i].want);
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 85 : 0;
      drain();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (window_left == 0) begin
          window_left = $urandom_range(20, 80);
          alloc_heavy = !alloc_heavy;
        end
        window_left--;
        pick_command(alloc_heavy ? 85 : 10, cmd, idx, gen);
        sender_gap();
        if ($urandom_range(199) == 0) drain();
        issue(cmd, idx, gen, 1'b0, '0);
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gha_pkg.sv
src/gha_ram.sv
src/gha_ctrl.sv
src/generational_handle_allocator.sv
tb/sv/generational_handle_allocator_tb.sv
